FILE: rtl/core/ssv_pkg.sv
`default_nettype none

package ssv_pkg;

  localparam int MAX_RADIUS   = 63;
  localparam int WORLD_HEIGHT = 256;

  localparam int CX_W   = 16;
  localparam int CY_W   = 8;
  localparam int R_W    = 6;
  localparam int MAT_W  = 8;
  localparam int OFS_W  = R_W + 1;
  localparam int VXZ_W  = CX_W + 1;
  localparam int VY_W   = 10;
  localparam int SQ_W   = 2 * OFS_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [IDX_W-1:0] REG_CENTER_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_Z  = 3'd2;
  localparam logic [IDX_W-1:0] REG_RADIUS    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SOLID     = 3'd4;
  localparam logic [IDX_W-1:0] REG_FLAT_AXIS = 3'd5;
  localparam logic [IDX_W-1:0] REG_MATERIAL  = 3'd6;

  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_X    = 2'd1;
  localparam logic [1:0] AXIS_Y    = 2'd2;
  localparam logic [1:0] AXIS_Z    = 2'd3;

  localparam logic [R_W-1:0] R_LIMIT = R_W'(MAX_RADIUS);
  localparam logic signed [VY_W-1:0] Y_TOP = VY_W'(WORLD_HEIGHT);

  typedef struct packed {
    logic signed [CX_W-1:0] center_x;
    logic [CY_W-1:0]        center_y;
    logic signed [CX_W-1:0] center_z;
    logic [R_W-1:0]         radius;
    logic                   solid;
    logic [1:0]             flat_axis;
    logic [MAT_W-1:0]       material;
  } cfg_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] dx;
    logic signed [OFS_W-1:0] dy;
    logic signed [OFS_W-1:0] dz;
    logic                    last;
  } scan_item_t;

  function automatic logic [R_W-1:0] clamp_radius(input logic [R_W-1:0] r);
    return (r > R_LIMIT) ? R_LIMIT : r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ssv_front.sv
`default_nettype none

module ssv_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ssv_pkg::cfg_t    cfg,
  input  wire logic             take,
  input  wire logic             restart,
  output ssv_pkg::scan_item_t   item
);

  logic signed [ssv_pkg::OFS_W-1:0] scan_dx, scan_dy, scan_dz;
  logic signed [ssv_pkg::OFS_W-1:0] scan_dx_next, scan_dy_next, scan_dz_next;
  logic scan_fresh, scan_fresh_next;

  logic signed [ssv_pkg::OFS_W-1:0] rs, neg_r, bx, by, bz;
  logic ax, ay, az, start;

  always_comb begin
    rs    = $signed({1'b0, ssv_pkg::clamp_radius(cfg.radius)});
    neg_r = -rs;
    ax    = cfg.flat_axis != ssv_pkg::AXIS_X;
    ay    = cfg.flat_axis != ssv_pkg::AXIS_Y;
    az    = cfg.flat_axis != ssv_pkg::AXIS_Z;
    start = restart || scan_fresh;

    // offsets of this candidate, held axis pinned at zero
    bx = !ax ? '0 : (start ? neg_r : scan_dx);
    by = !ay ? '0 : (start ? neg_r : scan_dy);
    bz = !az ? '0 : (start ? neg_r : scan_dz);

    item.dx   = bx;
    item.dy   = by;
    item.dz   = bz;
    item.last = (!ax || bx >= rs) && (!ay || by >= rs) && (!az || bz >= rs);

    // odometer step, z fastest
    scan_dx_next    = bx;
    scan_dy_next    = by;
    scan_dz_next    = bz;
    scan_fresh_next = 1'b0;
    if (az && bz < rs) begin
      scan_dz_next = bz + 1'b1;
    end else begin
      if (az) scan_dz_next = neg_r;
      if (ay && by < rs) begin
        scan_dy_next = by + 1'b1;
      end else begin
        if (ay) scan_dy_next = neg_r;
        if (ax && bx < rs) scan_dx_next = bx + 1'b1;
        else scan_fresh_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_dx    <= '0;
      scan_dy    <= '0;
      scan_dz    <= '0;
      scan_fresh <= 1'b1;
    end else if (take) begin
      scan_dx    <= scan_dx_next;
      scan_dy    <= scan_dy_next;
      scan_dz    <= scan_dz_next;
      scan_fresh <= scan_fresh_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ssv_queue.sv
`default_nettype none

module ssv_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ssv_pkg::scan_item_t  push_item,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      empty,
  output ssv_pkg::scan_item_t       head
);

  ssv_pkg::scan_item_t mem [ssv_pkg::QUEUE_DEPTH];
  logic [ssv_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [ssv_pkg::QPTR_W:0]   count;

  assign full  = count == (ssv_pkg::QPTR_W+1)'(ssv_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ssv_back.sv
`default_nettype none

module ssv_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire ssv_pkg::cfg_t                    cfg,
  input  wire logic                             have_item,
  input  wire ssv_pkg::scan_item_t              item,
  output logic                                  pop,
  output logic                                  voxel_valid,
  input  wire logic                             voxel_ready,
  output logic signed [ssv_pkg::VXZ_W-1:0]      vox_x,
  output logic signed [ssv_pkg::VY_W-1:0]       vox_y,
  output logic signed [ssv_pkg::VXZ_W-1:0]      vox_z,
  output logic [ssv_pkg::MAT_W-1:0]             block_type,
  output logic                                  place,
  output logic                                  last
);

  logic [ssv_pkg::R_W-1:0]   mx, my, mz, r;
  logic [ssv_pkg::SQ_W-1:0]  nx, ny, nz, fx, fy, fz;
  logic [ssv_pkg::SUM_W-1:0] near_sum, far_sum, four_r2;
  logic signed [ssv_pkg::VY_W-1:0] y;
  logic is_inside, outside;

  function automatic logic [ssv_pkg::R_W-1:0] mag(input logic signed [ssv_pkg::OFS_W-1:0] d);
    logic signed [ssv_pkg::OFS_W-1:0] n;
    n = d[ssv_pkg::OFS_W-1] ? -d : d;
    return n[ssv_pkg::R_W-1:0];
  endfunction

  // nearest corner: (2a-1)^2, which is 1 at the centre axis
  function automatic logic [ssv_pkg::SQ_W-1:0] near_sq(input logic [ssv_pkg::R_W-1:0] a);
    logic [ssv_pkg::OFS_W-1:0] t;
    t = (a == '0) ? ssv_pkg::OFS_W'(1) : ({a, 1'b0} - 1'b1);
    return ssv_pkg::SQ_W'(t) * ssv_pkg::SQ_W'(t);
  endfunction

  function automatic logic [ssv_pkg::SQ_W-1:0] far_sq(input logic [ssv_pkg::R_W-1:0] a);
    logic [ssv_pkg::OFS_W-1:0] t;
    t = {a, 1'b1};
    return ssv_pkg::SQ_W'(t) * ssv_pkg::SQ_W'(t);
  endfunction

  always_comb begin
    r  = ssv_pkg::clamp_radius(cfg.radius);
    mx = mag(item.dx);
    my = mag(item.dy);
    mz = mag(item.dz);
    nx = near_sq(mx);
    ny = near_sq(my);
    nz = near_sq(mz);
    fx = far_sq(mx);
    fy = far_sq(my);
    fz = far_sq(mz);
    near_sum  = ssv_pkg::SUM_W'(nx) + ssv_pkg::SUM_W'(ny) + ssv_pkg::SUM_W'(nz);
    far_sum   = ssv_pkg::SUM_W'(fx) + ssv_pkg::SUM_W'(fy) + ssv_pkg::SUM_W'(fz);
    four_r2   = {ssv_pkg::SQ_W'(r) * ssv_pkg::SQ_W'(r), 2'b00};
    is_inside = near_sum < four_r2;
    outside   = cfg.solid || (far_sum >= four_r2);
    y = $signed({2'b00, cfg.center_y}) + ssv_pkg::VY_W'(item.dy);
  end

  assign pop = have_item && (!voxel_valid || voxel_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      voxel_valid <= 1'b0;
    end else if (pop) begin
      voxel_valid <= 1'b1;
    end else if (voxel_ready) begin
      voxel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      vox_x      <= ssv_pkg::VXZ_W'(cfg.center_x) + ssv_pkg::VXZ_W'(item.dx);
      vox_y      <= y;
      vox_z      <= ssv_pkg::VXZ_W'(cfg.center_z) + ssv_pkg::VXZ_W'(item.dz);
      block_type <= cfg.material;
      place      <= is_inside && outside && (y > 0) && (y < ssv_pkg::Y_TOP);
      last       <= item.last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sphere_shell_voxelizer.sv
`default_nettype none

// sphere / circle voxel scanner
//
// tick channel (tick_valid, tick_ready, restart): every transfer asks for
// one candidate voxel; restart=1 begins the scan again at its first voxel.
// voxel channel (voxel_valid, voxel_ready, vox_x/y/z, block_type, place,
// last): one result per tick transfer, in order, last marks the final
// candidate of the scan (x outermost, then y, z innermost).
// config: cfg_we writes cfg_data into register cfg_index (0 center_x,
// 1 center_y, 2 center_z, 3 radius, 4 solid, 5 flat_axis, 6 material);
// write only while no result is outstanding.
// path: the scan step lands in the queue at the tick transfer edge, and the
// corner test feeds the output register, where the result becomes valid.
// throughput: one tick per cycle while the queue has room; the front scan
// counter and the back corner test sit on either side of a four entry queue.
// receiver stall: the output register holds, the queue fills, and
// tick_ready drops when the queue is full; nothing is lost.
// reset: config zero, queue empty, next tick starts a fresh scan.
module sphere_shell_voxelizer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [ssv_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [ssv_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                             tick_valid,
  output logic                                  tick_ready,
  input  wire logic                             restart,
  output logic                                  voxel_valid,
  input  wire logic                             voxel_ready,
  output logic signed [ssv_pkg::VXZ_W-1:0]      vox_x,
  output logic signed [ssv_pkg::VY_W-1:0]       vox_y,
  output logic signed [ssv_pkg::VXZ_W-1:0]      vox_z,
  output logic [ssv_pkg::MAT_W-1:0]             block_type,
  output logic                                  place,
  output logic                                  last
);

  ssv_pkg::cfg_t       cfg;
  ssv_pkg::scan_item_t front_item, head_item;
  logic take, full, empty, pop;

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssv_pkg::REG_CENTER_X:  cfg.center_x  <= $signed(cfg_data[ssv_pkg::CX_W-1:0]);
        ssv_pkg::REG_CENTER_Y:  cfg.center_y  <= cfg_data[ssv_pkg::CY_W-1:0];
        ssv_pkg::REG_CENTER_Z:  cfg.center_z  <= $signed(cfg_data[ssv_pkg::CX_W-1:0]);
        ssv_pkg::REG_RADIUS:    cfg.radius    <= cfg_data[ssv_pkg::R_W-1:0];
        ssv_pkg::REG_SOLID:     cfg.solid     <= cfg_data[0];
        ssv_pkg::REG_FLAT_AXIS: cfg.flat_axis <= cfg_data[1:0];
        ssv_pkg::REG_MATERIAL:  cfg.material  <= cfg_data[ssv_pkg::MAT_W-1:0];
        default: ;
      endcase
    end
  end

  // front side accepts as long as the queue has room
  assign tick_ready = !full;
  assign take       = tick_valid && tick_ready;

  ssv_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .take    (take),
    .restart (restart),
    .item    (front_item)
  );

  ssv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_item (front_item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head_item)
  );

  // back side: corner test straight into the output register
  ssv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .have_item   (!empty),
    .item        (head_item),
    .pop         (pop),
    .voxel_valid (voxel_valid),
    .voxel_ready (voxel_ready),
    .vox_x       (vox_x),
    .vox_y       (vox_y),
    .vox_z       (vox_z),
    .block_type  (block_type),
    .place       (place),
    .last        (last)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int STALL_CYCLES   = 300;
  localparam int ITEMS_PER_MODE = 350;

  // one candidate voxel as it leaves the block
  typedef struct packed {
    logic signed [ssv_pkg::VXZ_W-1:0] x;
    logic signed [ssv_pkg::VY_W-1:0]  y;
    logic signed [ssv_pkg::VXZ_W-1:0] z;
    logic [ssv_pkg::MAT_W-1:0]        mat;
    logic                             place;
    logic                             last;
  } voxel_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [ssv_pkg::IDX_W-1:0]        cfg_index = '0;
  logic [ssv_pkg::CFG_W-1:0]        cfg_data = '0;
  logic                             tick_valid = 1'b0;
  logic                             tick_ready;
  logic                             restart = 1'b0;
  logic                             voxel_valid;
  logic                             voxel_ready = 1'b0;
  logic signed [ssv_pkg::VXZ_W-1:0] vox_x;
  logic signed [ssv_pkg::VY_W-1:0]  vox_y;
  logic signed [ssv_pkg::VXZ_W-1:0] vox_z;
  logic [ssv_pkg::MAT_W-1:0]        block_type;
  logic                             place;
  logic                             last;

  sphere_shell_voxelizer uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .tick_valid  (tick_valid),
    .tick_ready  (tick_ready),
    .restart     (restart),
    .voxel_valid (voxel_valid),
    .voxel_ready (voxel_ready),
    .vox_x       (vox_x),
    .vox_y       (vox_y),
    .vox_z       (vox_z),
    .block_type  (block_type),
    .place       (place),
    .last        (last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // restart bits waiting to be offered, and voxels predicted but not yet seen
  bit     ticks_pending[$];
  voxel_t voxels_due[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  errors = 0;
  int  cycles = 0;
  int  stall_req = 0;
  int  stall_ack = 0;
  int  stall_left = 0;
  bit  tick_taken = 1'b0;

  // shadow of the register file plus the scan position
  ssv_pkg::cfg_t settings = '0;
  int   scan_x = 0;
  int   scan_y = 0;
  int   scan_z = 0;
  bit   scan_restart_due = 1'b1;

  // squared corner distance along one axis, in half units: (2|d| + s)^2
  function automatic int corner_sq(input int d, input int s);
    int m;
    m = (d < 0) ? -d : d;
    return (2 * m + s) * (2 * m + s);
  endfunction

  // computes the voxel for one tick transfer and steps the scan
  function automatic voxel_t next_candidate(input logic restart_req);
    int     r, cx, cy, cz, y, near_sum, far_sum, rr4;
    bit     sx, sy, sz, is_inside, outside;
    voxel_t v;
    r = int'(settings.radius);
    if (r > ssv_pkg::MAX_RADIUS) r = ssv_pkg::MAX_RADIUS;
    // an axis is scanned unless it is the one held at the centre
    sx = (settings.flat_axis != ssv_pkg::AXIS_X);
    sy = (settings.flat_axis != ssv_pkg::AXIS_Y);
    sz = (settings.flat_axis != ssv_pkg::AXIS_Z);
    if (restart_req || scan_restart_due) begin
      scan_x = -r;
      scan_y = -r;
      scan_z = -r;
      scan_restart_due = 1'b0;
    end
    if (!sx) scan_x = 0;
    if (!sy) scan_y = 0;
    if (!sz) scan_z = 0;

    // nearest corner strictly inside, farthest corner on or beyond the radius
    near_sum  = corner_sq(scan_x, -1) + corner_sq(scan_y, -1) + corner_sq(scan_z, -1);
    far_sum   = corner_sq(scan_x, 1) + corner_sq(scan_y, 1) + corner_sq(scan_z, 1);
    rr4       = 4 * r * r;
    is_inside = (near_sum < rr4);
    outside   = settings.solid || (far_sum >= rr4);

    cx = int'($signed(settings.center_x));
    cy = int'(settings.center_y);
    cz = int'($signed(settings.center_z));
    y  = cy + scan_y;

    v.x     = ssv_pkg::VXZ_W'(cx + scan_x);
    v.y     = ssv_pkg::VY_W'(y);
    v.z     = ssv_pkg::VXZ_W'(cz + scan_z);
    v.mat   = settings.material;
    v.place = is_inside && outside && (y > 0) && (y < ssv_pkg::WORLD_HEIGHT);
    v.last  = (!sx || scan_x >= r) && (!sy || scan_y >= r) && (!sz || scan_z >= r);

    // z innermost; an offset at or past r carries back to -r
    if (sz && scan_z < r) begin
      scan_z++;
    end else begin
      if (sz) scan_z = -r;
      if (sy && scan_y < r) begin
        scan_y++;
      end else begin
        if (sy) scan_y = -r;
        if (sx && scan_x < r) scan_x++;
        else scan_restart_due = 1'b1;
      end
    end
    return v;
  endfunction

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // sender: a new tick goes out only once the previous one was transferred
  always @(negedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!tick_valid || tick_taken) begin
      if (ticks_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        tick_valid <= 1'b1;
        restart    <= ticks_pending.pop_front();
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (rst) begin
      voxel_ready <= 1'b0;
    end else if (stall_req != stall_ack) begin
      stall_ack   <= stall_req;
      stall_left  <= STALL_CYCLES;
      voxel_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      voxel_ready <= 1'b0;
    end else begin
      voxel_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: predict on each tick transfer, check each voxel transfer
  always @(posedge clk) begin : monitor
    voxel_t want;
    if (rst) begin
      tick_taken <= 1'b0;
    end else begin
      tick_taken <= tick_valid && tick_ready;
      if (tick_valid && tick_ready) voxels_due.push_back(next_candidate(restart));
      if (voxel_valid && voxel_ready) begin
        if (voxels_due.size() == 0) begin
          errors++;
          $display("%0t ns: voxel (%0d,%0d,%0d), expected none, got a transfer",
                   $time, vox_x, vox_y, vox_z);
        end else begin
          want = voxels_due.pop_front();
          compare_field("vox_x", want.x, vox_x);
          compare_field("vox_y", want.y, vox_y);
          compare_field("vox_z", want.z, vox_z);
          compare_field("block_type", want.mat, block_type);
          compare_field("place", want.place, place);
          compare_field("last", want.last, last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // register write on the next falling edge; the shadow follows at once since
  // nothing is in flight when this is called
  task automatic write_reg(input logic [ssv_pkg::IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ssv_pkg::CFG_W'(value);
    case (idx)
      ssv_pkg::REG_CENTER_X:  settings.center_x  = ssv_pkg::CX_W'(value);
      ssv_pkg::REG_CENTER_Y:  settings.center_y  = ssv_pkg::CY_W'(value);
      ssv_pkg::REG_CENTER_Z:  settings.center_z  = ssv_pkg::CX_W'(value);
      ssv_pkg::REG_RADIUS:    settings.radius    = ssv_pkg::R_W'(value);
      ssv_pkg::REG_SOLID:     settings.solid     = value[0];
      ssv_pkg::REG_FLAT_AXIS: settings.flat_axis = value[1:0];
      ssv_pkg::REG_MATERIAL:  settings.material  = ssv_pkg::MAT_W'(value);
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // idle means: nothing left to offer, no tick on the wire, no voxel due;
  // sampled at the rising edge so a transfer on that edge still counts
  task automatic wait_idle();
    do @(posedge clk);
    while (ticks_pending.size() != 0 || tick_valid || voxels_due.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  initial begin : stimulus
    int n, k, span, scan_len, budget, mode;
    bit stalled;
    stalled = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 32;
    recv_idle_pct = 79;

    // radius zero straight out of reset: every tick is a whole scan of one voxel
    ticks_pending.push_back(1'b0);
    ticks_pending.push_back(1'b1);
    ticks_pending.push_back(1'b0);
    wait_idle();

    // circle with x held, x low and z high in the coordinate range, floor at y=0,
    // material zero; one full scan plus the tick that starts the next one
    write_reg(ssv_pkg::REG_CENTER_X, 32'h8000);
    write_reg(ssv_pkg::REG_CENTER_Y, 0);
    write_reg(ssv_pkg::REG_CENTER_Z, 32'h7FFF);
    write_reg(ssv_pkg::REG_RADIUS, 1);
    write_reg(ssv_pkg::REG_SOLID, 0);
    write_reg(ssv_pkg::REG_FLAT_AXIS, ssv_pkg::AXIS_X);
    write_reg(ssv_pkg::REG_MATERIAL, 0);
    close_writes();
    for (k = 0; k < 10; k++) ticks_pending.push_back(1'b0);
    wait_idle();

    // ceiling at y=255, filled, z held, scan continues then restarts mid-way
    write_reg(ssv_pkg::REG_CENTER_X, 32'h7FFF);
    write_reg(ssv_pkg::REG_CENTER_Y, 255);
    write_reg(ssv_pkg::REG_CENTER_Z, 32'h8000);
    write_reg(ssv_pkg::REG_RADIUS, 2);
    write_reg(ssv_pkg::REG_SOLID, 1);
    write_reg(ssv_pkg::REG_FLAT_AXIS, ssv_pkg::AXIS_Z);
    write_reg(ssv_pkg::REG_MATERIAL, 255);
    close_writes();
    for (k = 0; k < 4; k++) ticks_pending.push_back(1'b0);
    ticks_pending.push_back(1'b1);
    for (k = 0; k < 2; k++) ticks_pending.push_back(1'b0);
    wait_idle();

    // shrink the radius mid-scan and switch to the full sphere: offsets
    // beyond the new radius have to carry
    write_reg(ssv_pkg::REG_RADIUS, 1);
    write_reg(ssv_pkg::REG_FLAT_AXIS, ssv_pkg::AXIS_NONE);
    close_writes();
    for (k = 0; k < 5; k++) ticks_pending.push_back(1'b0);

    // random part in three idling modes; the last one has no idling and
    // carries the long receiver hold-off
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 32; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      budget = 0;
      while (budget < ITEMS_PER_MODE) begin
        wait_idle();
        if ($urandom_range(0, 1))
          write_reg(ssv_pkg::REG_CENTER_X, ($urandom_range(0, 3) == 0) ?
                    ($urandom_range(0, 1) ? 32'h7FFF : 32'h8000) : $urandom_range(0, 16'hFFFF));
        if ($urandom_range(0, 1))
          case ($urandom_range(0, 3))
            0: write_reg(ssv_pkg::REG_CENTER_Y, 0);
            1: write_reg(ssv_pkg::REG_CENTER_Y, 255);
            default: write_reg(ssv_pkg::REG_CENTER_Y, $urandom_range(0, 255));
          endcase
        if ($urandom_range(0, 1))
          write_reg(ssv_pkg::REG_CENTER_Z, ($urandom_range(0, 3) == 0) ?
                    ($urandom_range(0, 1) ? 32'h7FFF : 32'h8000) : $urandom_range(0, 16'hFFFF));
        // mostly small radii so whole scans fit; now and then zero or the maximum
        case ($urandom_range(0, 9))
          0: write_reg(ssv_pkg::REG_RADIUS, 0);
          1: write_reg(ssv_pkg::REG_RADIUS, ssv_pkg::MAX_RADIUS);
          2, 3, 4, 5, 6: write_reg(ssv_pkg::REG_RADIUS, $urandom_range(1, 3));
          default: write_reg(ssv_pkg::REG_RADIUS, $urandom_range(4, 20));
        endcase
        if ($urandom_range(0, 1)) write_reg(ssv_pkg::REG_SOLID, $urandom_range(0, 1));
        if ($urandom_range(0, 1)) write_reg(ssv_pkg::REG_FLAT_AXIS, $urandom_range(0, 3));
        if ($urandom_range(0, 1))
          write_reg(ssv_pkg::REG_MATERIAL, ($urandom_range(0, 3) == 0) ?
                    ($urandom_range(0, 1) ? 255 : 0) : $urandom_range(0, 255));
        close_writes();

        // whole scans where they are short, a partial stretch otherwise
        span     = 2 * int'(settings.radius) + 1;
        scan_len = span * span * ((settings.flat_axis == ssv_pkg::AXIS_NONE) ? span : 1);
        n = (scan_len <= 150) ? scan_len * $urandom_range(1, 2) : $urandom_range(40, 150);
        if (mode == 2 && !stalled && n < 80) n = 80;

        // well-formed: maybe a restart up front, then plain ticks with rare noise
        ticks_pending.push_back($urandom_range(0, 1) != 0);
        for (k = 1; k < n; k++) ticks_pending.push_back($urandom_range(0, 29) == 0);
        budget += n;

        if (mode == 2 && !stalled) begin
          stall_req++;
          stalled = 1'b1;
        end
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (errors == 0 && voxels_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
